>>> sv/max_neighbour_difference_3x3_unit_defines.svh
// Assertion macros shared by the max neighbour difference unit.
`ifndef MAX_NEIGHBOUR_DIFFERENCE_3X3_UNIT_DEFINES_SVH
`define MAX_NEIGHBOUR_DIFFERENCE_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define MND_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define MND_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mnd_pkg.sv
// Shared types and constants of the max neighbour difference unit.
package mnd_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Field and counter widths
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int POS_W      = 21;
    localparam int GRAY_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int DENS_W     = 5;
    localparam int DIV_CNT_W  = $clog2(POS_W);
    localparam int LUMA_SUM_W = 24;

    // Rec.709 luma weights in Q16
    localparam logic [15:0] LUMA_R = 16'd13933;
    localparam logic [15:0] LUMA_G = 16'd46871;
    localparam logic [15:0] LUMA_B = 16'd4732;

    // Item kinds carried in pixel_t.action
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     RESET_DIM        = DIM_W'(1024);

    // Input beat
    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    // Output beat
    typedef struct packed {
        logic [DENS_W-1:0] density;
        logic              frame_last;
    } result_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic [COL_W-1:0]  col;
        logic              has_result;
        logic              row_first;
        logic              row_last;
        logic              col_first;
        logic              col_last;
        logic              last;
    } item_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/mnd_div.sv
// Restoring divider: position into row and column after a width change.
module mnd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mnd_pkg::POS_W-1:0]   dividend,
    input  logic [mnd_pkg::DIM_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [mnd_pkg::POS_W-1:0]   quotient,
    output logic [mnd_pkg::COL_W-1:0]   remainder
);

    logic [mnd_pkg::POS_W-1:0]     quo_reg, quo_next;
    logic [mnd_pkg::DIM_W-1:0]     rem_reg, rem_next;
    logic [mnd_pkg::DIM_W-1:0]     dsr_reg;
    logic [mnd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [mnd_pkg::DIM_W:0]       trial;
    logic                          fits;

    // One quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[mnd_pkg::POS_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? mnd_pkg::DIM_W'(trial - {1'b0, dsr_reg})
                        : mnd_pkg::DIM_W'(trial);
        quo_next = {quo_reg[mnd_pkg::POS_W-2:0], fits};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mnd_pkg::DIV_CNT_W'(mnd_pkg::POS_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[mnd_pkg::COL_W-1:0];

endmodule

>>> sv/mnd_front.sv
// Front: configuration, position tracking and item classification.
module mnd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  mnd_pkg::pixel_t                 pixel_data,
    output logic                            pixel_stall,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mnd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mnd_pkg::DIM_W-1:0]       cfg_data,
    input  mnd_pkg::q_status_t              q_status,
    input  logic                            clear_busy,
    output logic                            push,
    output mnd_pkg::item_t                  push_item
);

    logic [mnd_pkg::DIM_W-1:0] width_reg, height_reg;
    logic [mnd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [mnd_pkg::POS_W-1:0] row_reg, row_next;
    logic [mnd_pkg::COL_W-1:0] col_reg, col_next;

    logic [mnd_pkg::DIM_W-1:0] w_eff, h_eff, new_w;
    logic [mnd_pkg::POS_W-1:0] h_ext, h_p1;
    logic                      wrap;
    logic [mnd_pkg::POS_W-1:0] n_pos, n_row;
    logic [mnd_pkg::COL_W-1:0] n_col;
    logic                      col_zero, col_end, is_pixel, accept, width_write;

    logic                      div_busy, div_done;
    logic [mnd_pkg::POS_W-1:0] div_quo;
    logic [mnd_pkg::COL_W-1:0] div_rem;

    function automatic logic [mnd_pkg::DIM_W-1:0] clamp_dim(
        input logic [mnd_pkg::DIM_W-1:0] v,
        input logic [mnd_pkg::DIM_W-1:0] top
    );
        logic [mnd_pkg::DIM_W-1:0] r;
        if (v == '0)
            r = mnd_pkg::DIM_W'(1);
        else if (v > top)
            r = top;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [mnd_pkg::GRAY_W-1:0] luma(
        input logic [mnd_pkg::CHAN_W-1:0] r,
        input logic [mnd_pkg::CHAN_W-1:0] g,
        input logic [mnd_pkg::CHAN_W-1:0] b
    );
        logic [mnd_pkg::LUMA_SUM_W-1:0] s;
        s = mnd_pkg::LUMA_SUM_W'(mnd_pkg::LUMA_R) * mnd_pkg::LUMA_SUM_W'(r)
          + mnd_pkg::LUMA_SUM_W'(mnd_pkg::LUMA_G) * mnd_pkg::LUMA_SUM_W'(g)
          + mnd_pkg::LUMA_SUM_W'(mnd_pkg::LUMA_B) * mnd_pkg::LUMA_SUM_W'(b);
        return s[mnd_pkg::LUMA_SUM_W-1:mnd_pkg::LUMA_SUM_W-mnd_pkg::GRAY_W];
    endfunction

    // Width change re-splits the stored position into row and column
    mnd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (width_write),
        .dividend  (pos_reg),
        .divisor   (new_w),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign cfg_ready   = 1'b1;
    assign width_write = cfg_valid && (cfg_index == mnd_pkg::REG_FRAME_WIDTH);
    assign new_w       = clamp_dim(cfg_data, mnd_pkg::DIM_W'(mnd_pkg::MAX_WIDTH));
    // held until the re-split row and column are loaded
    assign pixel_stall = q_status.full || clear_busy || div_busy || div_done || width_write;
    assign accept      = pixel_valid && !pixel_stall;
    assign push        = accept;

    // Classification of the current position
    always_comb
    begin
        w_eff    = clamp_dim(width_reg, mnd_pkg::DIM_W'(mnd_pkg::MAX_WIDTH));
        h_eff    = clamp_dim(height_reg, mnd_pkg::DIM_W'(mnd_pkg::MAX_HEIGHT));
        h_ext    = mnd_pkg::POS_W'(h_eff);
        h_p1     = h_ext + mnd_pkg::POS_W'(1);

        // beyond the frame's last item: start over
        wrap     = (row_reg > h_p1) || ((row_reg == h_p1) && (col_reg != '0));
        n_pos    = wrap ? '0 : pos_reg;
        n_row    = wrap ? '0 : row_reg;
        n_col    = wrap ? '0 : col_reg;

        col_zero = (n_col == '0);
        col_end  = (mnd_pkg::DIM_W'(n_col) + mnd_pkg::DIM_W'(1)) == w_eff;
        is_pixel = (pixel_data.action == mnd_pkg::ACT_PIXEL) && (n_row < h_ext);

        push_item.gray       = is_pixel
                             ? luma(pixel_data.red, pixel_data.green, pixel_data.blue)
                             : '0;
        push_item.col        = n_col;
        push_item.has_result = (n_row >= mnd_pkg::POS_W'(2))
                             || ((n_row == mnd_pkg::POS_W'(1)) && !col_zero);
        // judged pixel sits one position behind, one row up
        push_item.row_first  = col_zero ? (n_row == mnd_pkg::POS_W'(2))
                                        : (n_row == mnd_pkg::POS_W'(1));
        push_item.row_last   = col_zero ? (n_row == h_p1) : (n_row == h_ext);
        push_item.col_first  = (n_col == mnd_pkg::COL_W'(1))
                             || (col_zero && (w_eff == mnd_pkg::DIM_W'(1)));
        push_item.col_last   = col_zero;
        push_item.last       = col_zero && (n_row == h_p1);

        // advance
        if (push_item.last)
        begin
            pos_next = '0;
            row_next = '0;
            col_next = '0;
        end
        else
        begin
            pos_next = n_pos + mnd_pkg::POS_W'(1);
            row_next = col_end ? n_row + mnd_pkg::POS_W'(1) : n_row;
            col_next = col_end ? '0 : n_col + mnd_pkg::COL_W'(1);
        end
    end

    // Registers and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mnd_pkg::RESET_DIM;
            height_reg <= mnd_pkg::RESET_DIM;
            pos_reg    <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mnd_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    mnd_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (div_done)
            begin
                row_reg <= div_quo;
                col_reg <= div_rem;
            end
            else if (accept)
            begin
                pos_reg <= pos_next;
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

endmodule

>>> sv/mnd_queue.sv
// Short item queue between front and back.
module mnd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mnd_pkg::item_t     push_item,
    input  logic               pop,
    output mnd_pkg::item_t     head,
    output mnd_pkg::q_status_t status
);

    mnd_pkg::item_t             entry_reg [mnd_pkg::QUEUE_DEPTH];
    logic [mnd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mnd_pkg::QCNT_W-1:0] count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == mnd_pkg::QCNT_W'(mnd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> sv/mnd_back.sv
// Back: line buffers, 3x3 window and maximum difference pipeline.
module mnd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mnd_pkg::q_status_t q_status,
    input  mnd_pkg::item_t     q_head,
    output logic               pop,
    output logic               clear_busy,
    output logic               result_valid,
    input  logic               result_stall,
    output mnd_pkg::result_t   result_data
);

    typedef logic [mnd_pkg::GRAY_W-1:0] gray_t;

    // Line buffers
    gray_t upper_mem  [mnd_pkg::MAX_WIDTH];
    gray_t middle_mem [mnd_pkg::MAX_WIDTH];

    logic                      clr_busy_reg;
    logic [mnd_pkg::COL_W-1:0] clr_addr_reg;

    logic                      en, commit, fwd_next;
    logic                      mem_we;
    logic [mnd_pkg::COL_W-1:0] mem_addr;
    gray_t                     mem_up_wd, mem_mid_wd;

    // Stage 1: item with line buffer read data
    logic           s1_valid_reg;
    mnd_pkg::item_t s1_item_reg;
    gray_t          up_rd_reg, mid_rd_reg;
    logic           fwd_reg;
    gray_t          fwd_up_reg, fwd_mid_reg;
    gray_t          up_eff, mid_eff;

    // Window, stage 2 and stage 3
    logic [2:0][2:0][mnd_pkg::GRAY_W-1:0] win_reg;
    logic                                 s2_valid_reg;
    mnd_pkg::item_t                       s2_item_reg;
    logic [2:0][2:0][mnd_pkg::GRAY_W-1:0] diff_reg, diff_next;
    logic                                 s3_valid_reg;
    logic                                 s3_has_result_reg;
    logic                                 s3_last_reg;
    logic [2:0][mnd_pkg::GRAY_W-1:0]      row_max;
    gray_t                                best;

    logic             result_valid_reg;
    mnd_pkg::result_t result_data_reg;

    function automatic gray_t max3(input gray_t a, input gray_t b, input gray_t c);
        gray_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign en         = !result_valid_reg || !result_stall;
    assign pop        = en && !q_status.empty && !clr_busy_reg;
    assign commit     = en && s1_valid_reg;
    assign clear_busy = clr_busy_reg;

    // Same-column write in flight bypasses the buffer read
    assign up_eff   = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_eff  = fwd_reg ? fwd_mid_reg : mid_rd_reg;
    assign fwd_next = commit && (s1_item_reg.col == q_head.col);

    // Buffer write port: clearing pass, then item updates
    assign mem_we     = clr_busy_reg || commit;
    assign mem_addr   = clr_busy_reg ? clr_addr_reg : s1_item_reg.col;
    assign mem_up_wd  = clr_busy_reg ? '0 : mid_eff;
    assign mem_mid_wd = clr_busy_reg ? '0 : s1_item_reg.gray;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[mem_addr]  <= mem_up_wd;
            middle_mem[mem_addr] <= mem_mid_wd;
        end
        if (pop)
        begin
            up_rd_reg  <= upper_mem[q_head.col];
            mid_rd_reg <= middle_mem[q_head.col];
        end
    end

    // Masked absolute differences to the centre
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic  in_frame;
                gray_t v;
                in_frame = !((r == 0) && s2_item_reg.row_first)
                        && !((r == 2) && s2_item_reg.row_last)
                        && !((c == 0) && s2_item_reg.col_first)
                        && !((c == 2) && s2_item_reg.col_last);
                v = in_frame ? win_reg[r][c] : '0;
                if ((r == 1) && (c == 1))
                    diff_next[r][c] = '0;
                else if (v > win_reg[1][1])
                    diff_next[r][c] = v - win_reg[1][1];
                else
                    diff_next[r][c] = win_reg[1][1] - v;
            end
        end
    end

    // Maximum over the window
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            row_max[r] = max3(diff_reg[r][0], diff_reg[r][1], diff_reg[r][2]);
        best = max3(row_max[0], row_max[1], row_max[2]);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == mnd_pkg::COL_W'(mnd_pkg::MAX_WIDTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (en)
            begin
                s1_valid_reg     <= pop;
                s2_valid_reg     <= s1_valid_reg;
                s3_valid_reg     <= s2_valid_reg;
                result_valid_reg <= s3_valid_reg && s3_has_result_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= q_head;
            fwd_reg     <= fwd_next;
            fwd_up_reg  <= mid_eff;
            fwd_mid_reg <= s1_item_reg.gray;
        end
        if (commit)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_eff;
            win_reg[1][2] <= mid_eff;
            win_reg[2][2] <= s1_item_reg.gray;
        end
        if (en)
        begin
            s2_item_reg                <= s1_item_reg;
            diff_reg                   <= diff_next;
            s3_has_result_reg          <= s2_item_reg.has_result;
            s3_last_reg                <= s2_item_reg.last;
            result_data_reg.density    <= best[mnd_pkg::GRAY_W-1:mnd_pkg::GRAY_W-mnd_pkg::DENS_W];
            result_data_reg.frame_last <= s3_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

>>> sv/max_neighbour_difference_3x3_unit.sv
// Top level of the 3x3 maximum neighbour difference edge detector.
//
// Pixels enter in raster order on pixel_valid / pixel_stall / pixel_data; one beat
// a cycle is taken while pixel_stall is low. Each pixel becomes 8-bit
// gray, and the result for a pixel is the largest gray difference to its eight
// neighbours divided by 8 (outside neighbours read as zero). That result leaves
// on result_valid / result_stall / result_data when the beat frame_width + 1
// positions later is accepted; frame_width + 1 flush beats close a frame, and the
// frame's last result carries frame_last.
// Throughput: one beat per cycle unless stalled, set by the line buffers' single write port.
// A four-entry queue lets input keep flowing while a result waits on result_stall;
// when it fills, pixel_stall rises until the receiver takes results again.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, ready always
// high. A frame_width write re-splits the stored position, holding pixel_stall
// until the divider's new row and column are loaded.
// Reset: registers return to 1024 by 1024; a clearing pass over all 1024 columns
// zeroes the line buffers while pixel_stall is held high.
`include "max_neighbour_difference_3x3_unit_defines.svh"

module max_neighbour_difference_3x3_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  mnd_pkg::pixel_t               pixel_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output mnd_pkg::result_t              result_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mnd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mnd_pkg::DIM_W-1:0]     cfg_data
);

    mnd_pkg::q_status_t q_status;
    mnd_pkg::item_t     push_item;
    mnd_pkg::item_t     q_head;
    logic               push;
    logic               pop;
    logic               clear_busy;

    // Front: accept and classify
    mnd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_data  (pixel_data),
        .pixel_stall (pixel_stall),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .clear_busy  (clear_busy),
        .push        (push),
        .push_item   (push_item)
    );

    // Decoupling queue
    mnd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status)
    );

    // Back: window and difference
    mnd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_head       (q_head),
        .pop          (pop),
        .clear_busy   (clear_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Checks
    `MND_ASSERT_SAME(a_no_result_while_clearing, clear_busy, !result_valid, "result during clear")
    `MND_ASSERT_NEXT(a_width_write_holds_input, cfg_valid && cfg_ready && (cfg_index == mnd_pkg::REG_FRAME_WIDTH), pixel_stall, "input open during re-split")
    `MND_ASSERT_SAME(a_no_push_when_full, push, !q_status.full, "queue overflow")

endmodule

>>> verif/max_neighbour_difference_3x3_unit_tb.sv
// Self-checking testbench for the 3x3 max neighbour difference edge detector.
`timescale 1ns / 1ps

module max_neighbour_difference_3x3_unit_tb;

    // Cycles to let the pipeline settle once no result is pending
    localparam int SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 100000;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          pixel_valid  = 1'b0;
    logic                          pixel_stall;
    mnd_pkg::pixel_t               pixel_data   = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    mnd_pkg::result_t              result_data;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [mnd_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [mnd_pkg::DIM_W-1:0]     cfg_data     = '0;

    // Shadow of the block: geometry, line buffers, 3x3 window, frame position
    bit [mnd_pkg::DIM_W-1:0]  cfg_width  = mnd_pkg::DIM_W'(1024);
    bit [mnd_pkg::DIM_W-1:0]  cfg_height = mnd_pkg::DIM_W'(1024);
    bit [mnd_pkg::GRAY_W-1:0] row_above [mnd_pkg::MAX_WIDTH];
    bit [mnd_pkg::GRAY_W-1:0] row_middle [mnd_pkg::MAX_WIDTH];
    bit [mnd_pkg::GRAY_W-1:0] win [3][3];
    int unsigned              pos_count;

    mnd_pkg::result_t density_expected [$];
    int unsigned      mismatch_count;
    int unsigned      beats_sent;
    int unsigned      cycle_count;
    int unsigned      sender_idle_pct;
    int unsigned      receiver_stall_pct;

    max_neighbour_difference_3x3_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Compare each accepted result beat with the oldest expected one
    always @(posedge clk)
    begin : result_check
        mnd_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (density_expected.size() == 0)
            begin
                $display("%0t: unexpected result, got density %0d frame_last %0d",
                         $time, result_data.density, result_data.frame_last);
                mismatch_count++;
            end
            else
            begin
                want = density_expected.pop_front();
                if (result_data.density !== want.density)
                begin
                    $display("%0t: density mismatch, expected %0d, got %0d",
                             $time, want.density, result_data.density);
                    mismatch_count++;
                end
                if (result_data.frame_last !== want.frame_last)
                begin
                    $display("%0t: frame_last mismatch, expected %0d, got %0d",
                             $time, want.frame_last, result_data.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Out-of-range geometry: 0 acts as 1, anything above the limit as the limit
    function automatic int unsigned eff_dim(input bit [mnd_pkg::DIM_W-1:0] v,
                                            input int unsigned top);
        if (v == 0)
            return 1;
        if (32'(v) > top)
            return top;
        return 32'(v);
    endfunction

    // Q16 Rec.709 luma
    function automatic bit [mnd_pkg::GRAY_W-1:0] gray_of(input mnd_pkg::pixel_t beat);
        int unsigned sum;
        sum = 32'(mnd_pkg::LUMA_R) * 32'(beat.red) + 32'(mnd_pkg::LUMA_G) * 32'(beat.green)
            + 32'(mnd_pkg::LUMA_B) * 32'(beat.blue);
        return mnd_pkg::GRAY_W'(sum >> 16);
    endfunction

    // Advance the shadow by one accepted beat and queue the result it releases
    task automatic predict_density(input mnd_pkg::pixel_t beat);
        int unsigned w, h, total, n, col, p, pr, pc, centre, best, nb, diff;
        int r, k;
        bit [mnd_pkg::GRAY_W-1:0] g;
        bit in_frame;
        mnd_pkg::result_t want;
        w = eff_dim(cfg_width, mnd_pkg::MAX_WIDTH);
        h = eff_dim(cfg_height, mnd_pkg::MAX_HEIGHT);
        total = w * h;
        n = pos_count;
        if (n > total + w)
            n = 0;
        // flushes inside the frame read as black, pixels past it as flushes
        g = (beat.action == mnd_pkg::ACT_PIXEL && n < total) ? gray_of(beat) : '0;
        col = n % w;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = row_above[col];
        win[1][2] = row_middle[col];
        win[2][2] = g;
        row_above[col] = row_middle[col];
        row_middle[col] = g;

        // window now centred on pixel n - w - 1
        if (n >= w + 1)
        begin
            p = n - w - 1;
            pr = p / w;
            pc = p % w;
            centre = 32'(win[1][1]);
            best = 0;
            for (r = 0; r < 3; r++)
            begin
                for (k = 0; k < 3; k++)
                begin
                    if (r == 1 && k == 1)
                        continue;
                    in_frame = !((r == 0 && pr == 0) || (r == 2 && pr == h - 1) ||
                                 (k == 0 && pc == 0) || (k == 2 && pc == w - 1));
                    nb = in_frame ? 32'(win[r][k]) : 0;
                    diff = (nb > centre) ? nb - centre : centre - nb;
                    if (diff > best)
                        best = diff;
                end
            end
            want.density = mnd_pkg::DENS_W'(best >> 3);
            want.frame_last = (p == total - 1);
            density_expected.push_back(want);
        end
        pos_count = (n == total + w) ? 0 : n + 1;
    endtask

    // Drive one beat, with random idle cycles ahead of it
    task automatic send_beat(input mnd_pkg::pixel_t beat);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data <= beat;
        do @(posedge clk); while (pixel_stall);
        beats_sent++;
        predict_density(beat);
    endtask

    // Channels lean on the extremes so large differences turn up often
    function automatic mnd_pkg::pixel_t random_pixel();
        mnd_pkg::pixel_t beat;
        beat.action = mnd_pkg::ACT_PIXEL;
        beat.red   = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        beat.green = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
        beat.blue  = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
        if ($urandom_range(5) == 0)
            beat.green = 8'hFF;
        if ($urandom_range(5) == 0)
            beat.red = 8'h00;
        if ($urandom_range(5) == 0)
            beat.blue = 8'h00;
        return beat;
    endfunction

    // Stop sending, wait out every pending result, then let the pipeline settle
    task automatic wait_results_done();
        pixel_valid <= 1'b0;
        while (density_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both geometry registers back to back while the block is idle
    task automatic set_geometry(input logic [mnd_pkg::DIM_W-1:0] width,
                                input logic [mnd_pkg::DIM_W-1:0] height);
        wait_results_done();
        cfg_valid <= 1'b1;
        cfg_index <= mnd_pkg::REG_FRAME_WIDTH;
        cfg_data <= width;
        do @(posedge clk); while (!cfg_ready);
        cfg_width = width;
        cfg_index <= mnd_pkg::REG_FRAME_HEIGHT;
        cfg_data <= height;
        do @(posedge clk); while (!cfg_ready);
        cfg_height = height;
        cfg_valid <= 1'b0;
    endtask

    // Run the current frame to its end: pixels, then flushes, with optional noise
    task automatic send_frame(input int unsigned noise_pct);
        int unsigned w, total, pos;
        mnd_pkg::pixel_t beat;
        do
        begin
            w = eff_dim(cfg_width, mnd_pkg::MAX_WIDTH);
            total = w * eff_dim(cfg_height, mnd_pkg::MAX_HEIGHT);
            pos = (pos_count > total + w) ? 0 : pos_count;
            beat = random_pixel();
            beat.action = (pos < total) ? mnd_pkg::ACT_PIXEL : mnd_pkg::ACT_FLUSH;
            if ($urandom_range(99) < noise_pct)
                beat.action = ~beat.action;
            send_beat(beat);
        end
        while (pos_count != 0);
    endtask

    // Black, white and each primary in one small frame
    task automatic test_color_extremes();
        set_geometry(mnd_pkg::DIM_W'(3), mnd_pkg::DIM_W'(3));
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'h00, 8'h00});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h00, 8'hFF, 8'h00});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h80, 8'h40, 8'hC8});
        send_beat(random_pixel());
        send_frame(0);
    endtask

    // Flush inside the frame reads as black; a pixel in the tail acts as a flush
    task automatic test_flush_in_frame();
        set_geometry(mnd_pkg::DIM_W'(2), mnd_pkg::DIM_W'(2));
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_FLUSH, 8'hFF, 8'hFF, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00});
        send_beat(mnd_pkg::pixel_t'{mnd_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        send_frame(0);
    endtask

    // Geometry rewritten part way through a frame
    task automatic test_geometry_change();
        // position ends up past the new frame: restart at zero
        set_geometry(mnd_pkg::DIM_W'(3), mnd_pkg::DIM_W'(3));
        repeat (5) send_beat(random_pixel());
        set_geometry(mnd_pkg::DIM_W'(1), mnd_pkg::DIM_W'(1));
        send_frame(0);
        // position still inside the shorter frame: carry on
        set_geometry(mnd_pkg::DIM_W'(3), mnd_pkg::DIM_W'(3));
        repeat (2) send_beat(random_pixel());
        set_geometry(mnd_pkg::DIM_W'(3), mnd_pkg::DIM_W'(2));
        send_frame(0);
    endtask

    // Mostly small well-formed frames, some noisy or cut short
    task automatic test_random_frames(input int unsigned beat_target);
        int unsigned start, w, h, cut, i;
        mnd_pkg::pixel_t beat;
        start = beats_sent;
        while (beats_sent - start < beat_target)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            h = $urandom_range(6, 1);
            set_geometry(mnd_pkg::DIM_W'(w), mnd_pkg::DIM_W'(h));
            case ($urandom_range(9))
                0:
                begin
                    // cut short; the next geometry write lands mid-frame
                    cut = $urandom_range(w * h + w);
                    for (i = 0; i < cut; i++)
                    begin
                        beat = random_pixel();
                        beat.action = (pos_count < w * h) ? mnd_pkg::ACT_PIXEL
                                                          : mnd_pkg::ACT_FLUSH;
                        send_beat(beat);
                    end
                end
                1, 2:
                    send_frame(8);
                default:
                    send_frame(0);
            endcase
        end
    endtask

    // Smallest and clamped geometry; large frames are entered, then cut by a re-split
    task automatic test_geometry_extremes();
        set_geometry(mnd_pkg::DIM_W'(0), mnd_pkg::DIM_W'(0));
        send_frame(0);
        set_geometry(mnd_pkg::DIM_W'(2047), mnd_pkg::DIM_W'(2));
        repeat (24) send_beat(random_pixel());
        set_geometry(mnd_pkg::DIM_W'(1), mnd_pkg::DIM_W'(2047));
        repeat (24) send_beat(random_pixel());
        set_geometry(mnd_pkg::DIM_W'(3), mnd_pkg::DIM_W'(3));
        send_frame(0);
    endtask

    initial
    begin
        sender_idle_pct = 24;
        receiver_stall_pct = 74;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_color_extremes();
        test_flush_in_frame();
        test_geometry_change();
        test_random_frames(250);

        sender_idle_pct = 74;
        receiver_stall_pct = 24;
        test_random_frames(250);

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        test_random_frames(250);
        test_geometry_extremes();

        wait_results_done();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
